FILE: rtl/fmt_pkg.sv
// Shared types and constants for the framed Manchester transmitter.
// Used by every RTL module of the block except fmt_ram; depends on nothing else.
`default_nettype none

package fmt_pkg;

    // Command codes of an input item.
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // Frame phase codes, also shown on the result channel.
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_PRE   = 3'd1;
    localparam logic [2:0] PH_HDR   = 3'd2;
    localparam logic [2:0] PH_DATA  = 3'd3;
    localparam logic [2:0] PH_GUARD = 3'd4;

    // Configuration register indexes (word addresses).
    localparam logic [1:0] REG_FRAME_BYTES    = 2'd0;
    localparam logic [1:0] REG_PREAMBLE_TICKS = 2'd1;
    localparam logic [1:0] REG_GUARD_TICKS    = 2'd2;

    // Register reset values.
    localparam logic [5:0]  FRAME_BYTES_RST    = 6'd21;
    localparam logic [7:0]  PREAMBLE_TICKS_RST = 8'd32;
    localparam logic [15:0] GUARD_TICKS_RST    = 16'd200;

    // Frame layout.
    localparam int unsigned HDR_BYTES     = 2;
    localparam int unsigned MIN_FRAME     = 3;
    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned IDX_W         = 5;
    localparam int unsigned TICK_W        = 16;

    typedef struct packed {
        logic [5:0]  frame_bytes;
        logic [7:0]  preamble_ticks;
        logic [15:0] guard_ticks;
    } cfg_t;

    typedef struct packed {
        logic capture;  // latch the accepted input item
        logic exec;     // perform the frame step and load the result register
    } ctl_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/fmt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module fmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/fmt_regs.sv
// APB-style configuration registers of the framed Manchester transmitter.
// Depends on fmt_pkg for the register indexes, reset values and cfg_t.
`default_nettype none

module fmt_regs import fmt_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output cfg_t             cfg
);

    cfg_t       cfg_reg, cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_FRAME_BYTES:    cfg_next.frame_bytes    = pwdata[5:0];
                REG_PREAMBLE_TICKS: cfg_next.preamble_ticks = pwdata[7:0];
                REG_GUARD_TICKS:    cfg_next.guard_ticks    = pwdata[15:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_FRAME_BYTES:    prdata = {26'd0, cfg_reg.frame_bytes};
            REG_PREAMBLE_TICKS: prdata = {24'd0, cfg_reg.preamble_ticks};
            REG_GUARD_TICKS:    prdata = {16'd0, cfg_reg.guard_ticks};
            default:            prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_bytes    <= FRAME_BYTES_RST;
            cfg_reg.preamble_ticks <= PREAMBLE_TICKS_RST;
            cfg_reg.guard_ticks    <= GUARD_TICKS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/fmt_ctrl.sv
// Handshake controller of the framed Manchester transmitter.
// Depends on fmt_pkg for ctl_cmd_t; drives the datapath by capture and exec.
`default_nettype none

module fmt_ctrl import fmt_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  wire logic m_ready,
    output ctl_cmd_t  cmd
);

    typedef enum logic {
        ST_WAIT,
        ST_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   exec;

    // The step may run only when the result register is free or is being emptied.
    assign exec    = (state_reg == ST_EXEC) && (!out_valid_reg || m_ready);
    assign s_ready = (state_reg == ST_WAIT);
    assign m_valid = out_valid_reg;

    assign cmd.capture = s_valid && s_ready;
    assign cmd.exec    = exec;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_WAIT: if (s_valid) state_next = ST_EXEC;
            ST_EXEC: if (exec) state_next = ST_WAIT;
            default: state_next = ST_WAIT;
        endcase
        priority if (exec) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_WAIT;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_accept_then_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_EXEC))
        else $error("accepted item did not enter the step state");

    a_result_from_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(exec))
        else $error("result appeared without a step");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !cmd.exec)
        else $error("step would overwrite an untaken result");
`endif

endmodule

`default_nettype wire

FILE: rtl/fmt_datapath.sv
// Datapath of the framed Manchester transmitter: item register, frame buffer,
// phase and counters, line level coding and the result register.
// Depends on fmt_pkg and fmt_ram.
`default_nettype none

module fmt_datapath import fmt_pkg::*; #(
    parameter int MAX_FRAME_BYTES = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire ctl_cmd_t    cmd,
    input  wire cfg_t        cfg,
    input  wire logic [1:0]  s_command,
    input  wire logic [4:0]  s_byte_index,
    input  wire logic [7:0]  s_byte_value,
    output logic             m_line_level,
    output logic             m_busy_res,
    output logic             m_frame_done,
    output logic [2:0]       m_phase
);

    localparam int AW  = $clog2(MAX_FRAME_BYTES);
    localparam int CW  = ((AW + 1) > IDX_W) ? (AW + 1) : IDX_W;
    localparam int FBW = ($clog2(MAX_FRAME_BYTES + 1) > 6) ? $clog2(MAX_FRAME_BYTES + 1) : 6;
    localparam int TW  = ((FBW + 4) > TICK_W) ? (FBW + 4) : TICK_W;

    // Item register.
    logic [1:0]        cmd_reg;
    logic [4:0]        idx_reg;
    logic [7:0]        val_reg;

    // Frame state.
    logic [2:0]        phase_reg, phase_next;
    logic [15:0]       tc_reg, tc_next;
    logic [3:0]        bp_reg, bp_next;

    // Buffer access.
    logic              ram_we;
    logic [CW-1:0]     idx_ext;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [7:0]        ram_rdata;

    // Step results.
    logic              level, done;
    logic [2:0]        shown;

    // Frame length and data-phase tick total.
    logic [FBW-1:0]    fb_ext, eff_bytes;
    logic [TW-1:0]     total, tc_wide, tc_inc_wide;
    logic [15:0]       tc_inc, guard_len, guard_cnt;
    logic              data_end;

    assign idx_ext   = CW'(idx_reg);
    assign ram_waddr = idx_ext[AW-1:0];
    assign ram_we    = cmd.exec && (cmd_reg == CMD_LOAD) && (idx_ext < CW'(MAX_FRAME_BYTES));

    // The read address follows the current state, so the RAM registers the byte for the next
    // tick at the edge that accepts the item.
    always_comb begin
        if (phase_reg == PH_HDR) begin
            ram_raddr = AW'(bp_reg[3]);
        end else begin
            ram_raddr = AW'(tc_reg >> 4) + AW'(HDR_BYTES);
        end
    end

    fmt_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_FRAME_BYTES)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (val_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        fb_ext = FBW'(cfg.frame_bytes);
        priority if (fb_ext < FBW'(MIN_FRAME)) begin
            eff_bytes = FBW'(MIN_FRAME);
        end else if (fb_ext > FBW'(MAX_FRAME_BYTES)) begin
            eff_bytes = FBW'(MAX_FRAME_BYTES);
        end else begin
            eff_bytes = fb_ext;
        end
        total       = TW'(eff_bytes - FBW'(HDR_BYTES)) << 4;
        tc_inc      = tc_reg + 16'd1;
        tc_wide     = TW'(tc_reg);
        tc_inc_wide = TW'(tc_inc);
        guard_len   = (cfg.guard_ticks == 16'd0) ? 16'd1 : cfg.guard_ticks;
        data_end    = (phase_reg == PH_DATA) && (tc_wide >= total);
        // A data phase that is already over starts its guard count from zero.
        guard_cnt   = data_end ? 16'd1 : tc_inc;
    end

    always_comb begin
        phase_next = phase_reg;
        tc_next    = tc_reg;
        bp_next    = bp_reg;
        level      = 1'b0;
        done       = 1'b0;
        shown      = phase_reg;
        unique case (cmd_reg)
            CMD_LOAD: begin
                shown = phase_reg;
            end
            CMD_START: begin
                if (phase_reg == PH_IDLE) begin
                    tc_next    = 16'd0;
                    bp_next    = 4'd0;
                    phase_next = (cfg.preamble_ticks == 8'd0) ? PH_HDR : PH_PRE;
                    shown      = phase_next;
                end
            end
            CMD_TICK: begin
                priority if (phase_reg == PH_PRE) begin
                    level = ~tc_reg[0];
                    if (tc_inc >= 16'(cfg.preamble_ticks)) begin
                        phase_next = PH_HDR;
                        tc_next    = 16'd0;
                        bp_next    = 4'd0;
                    end else begin
                        tc_next = tc_inc;
                    end
                end else if (phase_reg == PH_HDR) begin
                    level = ram_rdata[3'd7 - bp_reg[2:0]];
                    if (bp_reg == 4'd15) begin
                        phase_next = PH_DATA;
                        tc_next    = 16'd0;
                        bp_next    = 4'd0;
                    end else begin
                        bp_next = bp_reg + 4'd1;
                    end
                end else if ((phase_reg == PH_DATA) && !data_end) begin
                    // Manchester: a one is high then low, a zero low then high.
                    level = ram_rdata[3'd7 - tc_reg[3:1]] ^ tc_reg[0];
                    if (tc_inc_wide >= total) begin
                        phase_next = PH_GUARD;
                        tc_next    = 16'd0;
                    end else begin
                        tc_next = tc_inc;
                    end
                end else if ((phase_reg == PH_GUARD) || data_end) begin
                    shown = PH_GUARD;
                    if (guard_cnt >= guard_len) begin
                        done       = 1'b1;
                        phase_next = PH_IDLE;
                        tc_next    = 16'd0;
                        bp_next    = 4'd0;
                    end else begin
                        phase_next = PH_GUARD;
                        tc_next    = guard_cnt;
                    end
                end else begin
                    phase_next = PH_IDLE;
                    shown      = PH_IDLE;
                end
            end
            default: begin
                shown = phase_reg;
            end
        endcase
    end

    // Item and result registers carry payload only.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cmd_reg <= s_command;
            idx_reg <= s_byte_index;
            val_reg <= s_byte_value;
        end
        if (cmd.exec) begin
            m_line_level <= level;
            m_busy_res   <= (shown != PH_IDLE);
            m_frame_done <= done;
            m_phase      <= shown;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            tc_reg    <= 16'd0;
            bp_reg    <= 4'd0;
        end else if (cmd.exec) begin
            phase_reg <= phase_next;
            tc_reg    <= tc_next;
            bp_reg    <= bp_next;
        end
    end

`ifndef SYNTHESIS
    a_bp_only_in_header: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_HDR) |-> (bp_reg == 4'd0))
        else $error("header bit counter nonzero outside the header");

    a_tc_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        ((phase_reg == PH_IDLE) || (phase_reg == PH_HDR)) |-> (tc_reg == 16'd0))
        else $error("tick counter nonzero in idle or header");

    a_done_in_guard: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |=> (!m_frame_done || ((m_phase == PH_GUARD) && (phase_reg == PH_IDLE))))
        else $error("frame done flagged outside the final guard tick");
`endif

endmodule

`default_nettype wire

FILE: rtl/framed_manchester_transmitter.sv
// Top level of the framed Manchester transmitter: configuration port,
// controller and datapath. Depends on fmt_pkg, fmt_regs, fmt_ctrl, fmt_datapath.
`default_nettype none

// Radio frame serializer driven by items. A load item writes one byte of the frame buffer,
// a start item begins a frame, and every tick item yields one line level. A frame is a
// preamble of alternating ticks (high first), 16 header bits from buffer bytes 0 and 1 sent
// NRZ MSB first, the remaining bytes Manchester coded MSB first at two ticks per bit, and a
// run of low guard ticks, the last of which flags frame_done. Every item, of any command,
// returns exactly one result item. A result is registered by the step of its item, and that
// step may wait on the output register. The frame buffer is read at the accepting edge from
// the state that the previous step left, so the controller returns to its wait state after
// each step and takes no item while one waits for its step. The next item is accepted while a
// result still waits on the output register; its step then waits until that result is
// taken. Buffer bytes are undefined until loaded and there is no clearing pass after reset.
// Registers sit at byte addresses 0 (frame_bytes), 4 (preamble_ticks) and 8 (guard_ticks)
// and are to be written only while no item is in flight; a change in the middle of a frame
// takes effect at the next tick.
module framed_manchester_transmitter import fmt_pkg::*; #(
    parameter int MAX_FRAME_BYTES = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_command,
    input  wire logic [4:0]  s_byte_index,
    input  wire logic [7:0]  s_byte_value,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_line_level,
    output logic             m_busy_res,
    output logic             m_frame_done,
    output logic [2:0]       m_phase,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    cfg_t     cfg;
    ctl_cmd_t cmd;

    // Configuration registers; the datapath sees their values directly.
    fmt_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The controller owns both handshakes and the result valid flag.
    fmt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // The datapath holds the frame buffer, phase, counters and result payload.
    fmt_datapath #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .cfg          (cfg),
        .s_command    (s_command),
        .s_byte_index (s_byte_index),
        .s_byte_value (s_byte_value),
        .m_line_level (m_line_level),
        .m_busy_res   (m_busy_res),
        .m_frame_done (m_frame_done),
        .m_phase      (m_phase)
    );

endmodule

`default_nettype wire
